@@ sv/lkv_pkg.sv @@
package lkv_pkg;

   // field widths fixed by the interface
   localparam int CAP_BITS  = 5;
   localparam int DATA_BITS = 32;

   // capacity register value after reset
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // read_value returned by a get that misses
   localparam logic [DATA_BITS-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   // request codes
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_UPD  = 3'b100
   } state_type;

   // per-cell update control
   typedef struct packed {
      logic shift;   // take the neighbour's entry
      logic clear;   // drop the entry (wins over shift)
   } cell_ctrl_type;

endpackage

@@ sv/lru_key_value_cache.sv @@
// Channel  Direction  Handshake              Beat contents
// req      in         req_valid / req_stall  req_type, req_key, req_value
// rsp      out        rsp_valid / rsp_stall  rsp_hit, rsp_read_value (gets only)
// csr      in         csr_valid / csr_ready  csr_data = capacity
//
// Entries sit in a row of cells ordered by recency, cell 0 most recent.
// An item has a compare cycle across all cells, then an update cycle that shifts
// the row by one cell, except on a get miss; the next beat is taken in the update cycle.
// A get result appears on rsp the cycle after its update and waits in an output
// register; the update of a further get stalls req while that result is not taken.
// Synchronous reset empties every cell and sets capacity to 16.
module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [DATA_BITS-1:0] req_key,
   input  logic [DATA_BITS-1:0] req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic [DATA_BITS-1:0] rsp_read_value,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CAP_BITS-1:0]  csr_data
);

   localparam int OCC_BITS = $clog2(ENTRIES + 1);
   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CMP_BITS = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;
   localparam logic [CMP_BITS-1:0] ENT_CMP = CMP_BITS'(ENTRIES);
   localparam logic [CMP_BITS-1:0] ONE_CMP = CMP_BITS'(1);
   localparam logic [OCC_BITS-1:0] ONE_OCC = OCC_BITS'(1);

   state_type state_ff, state_in;

   logic [CAP_BITS-1:0]   cap_ff;
   logic [OCC_BITS-1:0]   occ_ff;
   logic                  type_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [KEY_BITS-1:0]   key_in;
   logic [VALUE_BITS-1:0] value_in;

   // update plan, registered at the end of the compare cycle
   logic                  is_get_ff;
   logic                  hit_ff;
   logic                  do_shift_ff;
   logic [OCC_BITS-1:0]   limit_ff;
   logic                  clr_en_ff;
   logic [OCC_BITS-1:0]   clr_pos_ff;
   logic [OCC_BITS-1:0]   occ_new_ff;
   logic [VALUE_BITS-1:0] new_value_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [DATA_BITS-1:0]  rsp_value_ff;

   logic [KEY_BITS-1:0]   c_key   [ENTRIES];
   logic [VALUE_BITS-1:0] c_value [ENTRIES];
   logic                  c_valid [ENTRIES];
   logic [ENTRIES-1:0]    match;
   cell_ctrl_type         ctrl    [ENTRIES];

   logic                  any_hit;
   logic [IDX_BITS-1:0]   hit_pos;
   logic [VALUE_BITS-1:0] hit_value;
   logic [CMP_BITS-1:0]   cap_eff;
   logic [CMP_BITS-1:0]   occ_cmp;
   logic [CMP_BITS-1:0]   occ_less;
   logic                  do_shift_in;
   logic [OCC_BITS-1:0]   limit_in;
   logic                  clr_en_in;
   logic [OCC_BITS-1:0]   occ_new_in;
   logic [VALUE_BITS-1:0] new_value_in;
   logic [DATA_BITS-1:0]  read_value;

   logic                  upd_go;
   logic                  req_take;

   // fit the key and value ports to the stored widths
   generate
      if (KEY_BITS <= DATA_BITS) begin : g_key_narrow
         assign key_in = req_key[KEY_BITS-1:0];
      end else begin : g_key_wide
         assign key_in = {{(KEY_BITS - DATA_BITS){1'b0}}, req_key};
      end
      if (VALUE_BITS <= DATA_BITS) begin : g_val_narrow
         assign value_in = req_value[VALUE_BITS-1:0];
         always_comb begin
            read_value = DATA_BITS'(new_value_ff);
         end
      end else begin : g_val_wide
         assign value_in = {{(VALUE_BITS - DATA_BITS){1'b0}}, req_value};
         always_comb begin
            read_value = new_value_ff[DATA_BITS-1:0];
         end
      end
   endgenerate

   // handshakes
   assign csr_ready = !reset;
   assign upd_go    = (state_ff == ST_UPD) && !(is_get_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = reset || !((state_ff == ST_IDLE) || upd_go);
   assign req_take  = req_valid && !req_stall;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (upd_go) begin
               state_in = req_valid ? ST_LOOK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff   <= CAP_RESET;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         if (upd_go) begin
            occ_ff <= occ_new_ff;
         end
      end
   end

   // hold the accepted beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         type_ff  <= req_type;
         key_ff   <= key_in;
         value_ff <= value_in;
      end
   end

   // row of cells, each fed by its more recent neighbour
   genvar gi;
   generate
      for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
         assign ctrl[gi].shift = upd_go && do_shift_ff && (OCC_BITS'(gi) <= limit_ff);
         assign ctrl[gi].clear = upd_go && clr_en_ff && (OCC_BITS'(gi) == clr_pos_ff);
         if (gi == 0) begin : g_head
            lkv_cell #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctrl       (ctrl[gi]),
               .prev_key   (key_ff),
               .prev_value (new_value_ff),
               .prev_valid (1'b1),
               .look_key   (key_ff),
               .cell_key   (c_key[gi]),
               .cell_value (c_value[gi]),
               .cell_valid (c_valid[gi]),
               .match      (match[gi])
            );
         end else begin : g_body
            lkv_cell #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_cell (
               .clock      (clock),
               .reset      (reset),
               .ctrl       (ctrl[gi]),
               .prev_key   (c_key[gi-1]),
               .prev_value (c_value[gi-1]),
               .prev_valid (c_valid[gi-1]),
               .look_key   (key_ff),
               .cell_key   (c_key[gi]),
               .cell_value (c_value[gi]),
               .cell_valid (c_valid[gi]),
               .match      (match[gi])
            );
         end
      end
   endgenerate

   // encode the matching cell; keys are unique among valid cells
   always_comb begin
      hit_pos   = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match[i]) begin
            hit_pos   = hit_pos | IDX_BITS'(i);
            hit_value = hit_value | c_value[i];
         end
      end
      any_hit = |match;
   end

   // effective capacity: zero acts as one, clip at the row length
   always_comb begin
      cap_eff = CMP_BITS'(cap_ff);
      if (cap_eff == '0) begin
         cap_eff = ONE_CMP;
      end else if (cap_eff > ENT_CMP) begin
         cap_eff = ENT_CMP;
      end
      occ_cmp  = CMP_BITS'(occ_ff);
      occ_less = occ_cmp - ONE_CMP;
   end

   // plan the shift, the drop and the new occupancy
   always_comb begin
      do_shift_in  = 1'b1;
      limit_in     = OCC_BITS'(hit_pos);
      clr_en_in    = 1'b0;
      occ_new_in   = occ_ff;
      new_value_in = value_ff;
      if (type_ff == REQ_GET) begin
         new_value_in = hit_value;
         do_shift_in  = any_hit;
      end else if (any_hit) begin
         // present key moves to the front; a lowered capacity may still evict
         if ((occ_less != '0) && (occ_less >= cap_eff)) begin
            clr_en_in  = 1'b1;
            occ_new_in = occ_ff - ONE_OCC;
         end
      end else if (occ_cmp >= cap_eff) begin
         // overwrite the least recent cell
         limit_in = occ_ff - ONE_OCC;
      end else begin
         limit_in   = occ_ff;
         occ_new_in = occ_ff + ONE_OCC;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOK) begin
         is_get_ff    <= (type_ff == REQ_GET);
         hit_ff       <= any_hit;
         do_shift_ff  <= do_shift_in;
         limit_ff     <= limit_in;
         clr_en_ff    <= clr_en_in;
         clr_pos_ff   <= occ_ff - ONE_OCC;
         occ_new_ff   <= occ_new_in;
         new_value_ff <= new_value_in;
      end
   end

   // output register: load on a get update, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_go && is_get_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_go && is_get_ff) begin
         rsp_hit_ff   <= hit_ff;
         rsp_value_ff <= hit_ff ? read_value : MISS_VALUE;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

@@ sv/lkv_cell.sv @@
module lkv_cell
   import lkv_pkg::*;
#(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [KEY_BITS-1:0]   prev_key,
   input  logic [VALUE_BITS-1:0] prev_value,
   input  logic                  prev_valid,
   input  logic [KEY_BITS-1:0]   look_key,
   output logic [KEY_BITS-1:0]   cell_key,
   output logic [VALUE_BITS-1:0] cell_value,
   output logic                  cell_valid,
   output logic                  match
);

   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  valid_ff;
   logic                  valid_in;

   // compare the held key against the request
   assign match = valid_ff && (key_ff == look_key);

   // drop wins over a shift from the neighbour
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.shift) begin
         valid_in = prev_valid;
      end
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload advances with the shift, no reset
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         key_ff   <= prev_key;
         value_ff <= prev_value;
      end
   end

   assign cell_key   = key_ff;
   assign cell_value = value_ff;
   assign cell_valid = valid_ff;

endmodule

@@ tb/sv/lru_key_value_cache_test.sv @@
`timescale 1ns / 100ps

module lru_key_value_cache_test;
   import lkv_pkg::*;

   localparam int NUM_SLOTS     = 16;
   localparam int IDLE_PERCENT  = 20;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;

   typedef struct packed {
      logic                 kind;
      logic [DATA_BITS-1:0] key;
      logic [DATA_BITS-1:0] data;
   } cache_req_type;

   typedef struct packed {
      logic                 hit;
      logic [DATA_BITS-1:0] read_value;
   } cache_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_type = REQ_GET;
   logic [DATA_BITS-1:0] req_key = '0;
   logic [DATA_BITS-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_hit;
   logic [DATA_BITS-1:0] rsp_read_value;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CAP_BITS-1:0]  csr_data = '0;

   // beats waiting to be driven and read results still owed by the block
   cache_req_type req_backlog[$];
   cache_rsp_type pending_reads[$];
   cache_rsp_type head_read;
   cache_req_type next_req;
   bit            beat_loaded = 1'b0;
   bit            calm = 1'b0;
   int            mismatches = 0;
   int            quiet_cycles = 0;

   // shadow copy of the cache contents
   logic [DATA_BITS-1:0] slot_key[NUM_SLOTS];
   logic [DATA_BITS-1:0] slot_val[NUM_SLOTS];
   bit                   slot_used[NUM_SLOTS];
   int unsigned          slot_age[NUM_SLOTS];
   int unsigned          fill_count = 0;
   logic [CAP_BITS-1:0]  capacity_reg = CAP_RESET;

   lru_key_value_cache DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   always #2 clock = ~clock;

   // drop an entry and close the gap in the ages behind it
   function automatic void vacate_slot(int s);
      int unsigned r;
      r = slot_age[s];
      slot_used[s] = 1'b0;
      slot_age[s] = 0;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (slot_used[i] && slot_age[i] > r) slot_age[i]--;
      if (fill_count > 0) fill_count--;
   endfunction

   function automatic void age_slots();
      for (int i = 0; i < NUM_SLOTS; i++)
         if (slot_used[i]) slot_age[i]++;
   endfunction

   // advance the shadow cache by one request; queue the read result of a get
   function automatic void update_cache_model(cache_req_type rq);
      int            hit_slot;
      int            lru;
      int            free_slot;
      int            limit;
      cache_rsp_type r;
      hit_slot = -1;
      lru = -1;
      free_slot = -1;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (slot_used[i] && slot_key[i] == rq.key) begin
            hit_slot = i;
            break;
         end
      if (rq.kind == REQ_GET) begin
         if (hit_slot < 0) begin
            r.hit = 1'b0;
            r.read_value = MISS_VALUE;
         end else begin
            vacate_slot(hit_slot);
            age_slots();
            slot_used[hit_slot] = 1'b1;
            slot_age[hit_slot] = 0;
            fill_count++;
            r.hit = 1'b1;
            r.read_value = slot_val[hit_slot];
         end
         pending_reads.push_back(r);
      end else begin
         if (hit_slot >= 0) vacate_slot(hit_slot);
         // zero acts as one, anything above the slot count as the slot count
         limit = (capacity_reg == 0) ? 1 :
                 (capacity_reg > NUM_SLOTS) ? NUM_SLOTS : int'(capacity_reg);
         if (fill_count > 0 && fill_count >= limit) begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (slot_used[i] && (lru < 0 || slot_age[i] > slot_age[lru])) lru = i;
            if (lru >= 0) vacate_slot(lru);
         end
         for (int i = 0; i < NUM_SLOTS; i++)
            if (!slot_used[i]) begin
               free_slot = i;
               break;
            end
         if (free_slot >= 0) begin
            age_slots();
            slot_used[free_slot] = 1'b1;
            slot_key[free_slot] = rq.key;
            slot_val[free_slot] = rq.data;
            slot_age[free_slot] = 0;
            fill_count++;
         end
      end
   endfunction

   // request driver: take the beat on acceptance, then load the next or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            update_cache_model('{kind: req_type, key: req_key, data: req_value});
            beat_loaded = 1'b0;
         end
         if (req_backlog.size() != 0 &&
             (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            next_req = req_backlog.pop_front();
            beat_loaded = 1'b1;
            req_valid <= 1'b1;
            req_type  <= next_req.kind;
            req_key   <= next_req.key;
            req_value <= next_req.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor: compare each beat taken with the oldest owed read
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_reads.size() == 0) begin
               $error("unexpected result: hit %0b read_value %h", rsp_hit, rsp_read_value);
               mismatches++;
            end else begin
               head_read = pending_reads.pop_front();
               if (rsp_hit !== head_read.hit) begin
                  $error("hit: expected %0b, got %0b", head_read.hit, rsp_hit);
                  mismatches++;
               end
               if (rsp_read_value !== head_read.read_value) begin
                  $error("read_value: expected %h, got %h",
                         head_read.read_value, rsp_read_value);
                  mismatches++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // watchdog: end the run when nothing has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_req(input logic kind, input logic [DATA_BITS-1:0] key,
                           input logic [DATA_BITS-1:0] data);
      req_backlog.push_back('{kind: kind, key: key, data: data});
   endtask

   // hold off until every beat is taken and every read is back, then let puts finish
   task automatic settle();
      while (req_backlog.size() != 0 || beat_loaded || pending_reads.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      capacity_reg = cap;
   endtask

   // random beats over a small key pool so that hits, updates and evictions are common
   task automatic queue_random(input int count, input int pool);
      logic [DATA_BITS-1:0] pool_base;
      logic [DATA_BITS-1:0] key;
      pool_base = $urandom;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 90) key = pool_base + $urandom_range(0, pool - 1);
         else key = $urandom;
         push_req(($urandom_range(0, 1) == 1) ? REQ_PUT : REQ_GET, key, $urandom);
      end
   endtask

   initial begin
      logic [CAP_BITS-1:0] caps[10];
      int                  eff;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_used[i] = 1'b0;
         slot_age[i] = 0;
      end
      caps = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd8, 5'd2, 5'd16, 5'd12, 5'd3};
      caps[8] = CAP_BITS'($urandom_range(1, 16));
      caps[9] = CAP_BITS'($urandom_range(0, 31));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: miss on empty, extreme keys and values, update in place
      push_req(REQ_GET, 32'h0000_0005, 32'h0);
      push_req(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      push_req(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      push_req(REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      push_req(REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      push_req(REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      push_req(REQ_GET, 32'h7FFF_FFFF, 32'h0);
      push_req(REQ_GET, 32'h0000_0000, 32'h0);
      push_req(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_req(REQ_PUT, 32'h0000_0000, 32'h1234_5678);
      push_req(REQ_GET, 32'h0000_0000, 32'h0);
      push_req(REQ_GET, 32'h0000_0005, 32'h0);
      settle();

      // capacity lowered below occupancy: each put evicts one entry only
      write_capacity(5'd2);
      push_req(REQ_PUT, 32'h0000_000A, 32'h0000_0001);
      push_req(REQ_PUT, 32'h0000_000B, 32'h0000_0002);
      push_req(REQ_GET, 32'h8000_0000, 32'h0);
      push_req(REQ_GET, 32'h7FFF_FFFF, 32'h0);
      push_req(REQ_GET, 32'h0000_0000, 32'h0);
      push_req(REQ_GET, 32'hFFFF_FFFF, 32'h0);
      push_req(REQ_GET, 32'h0000_000A, 32'h0);
      push_req(REQ_GET, 32'h0000_000B, 32'h0);
      settle();

      // zero capacity acts as one
      write_capacity(5'd0);
      push_req(REQ_PUT, 32'h0000_0014, 32'hA5A5_A5A5);
      push_req(REQ_GET, 32'h0000_0014, 32'h0);
      push_req(REQ_GET, 32'h0000_000B, 32'h0);
      push_req(REQ_PUT, 32'h0000_0015, 32'h5A5A_5A5A);
      push_req(REQ_GET, 32'h0000_0014, 32'h0);
      settle();

      // random phases, one per capacity setting; one phase runs with no idling
      for (int p = 0; p < 10; p++) begin
         write_capacity(caps[p]);
         eff = (caps[p] == 0) ? 1 : (caps[p] > NUM_SLOTS) ? NUM_SLOTS : int'(caps[p]);
         calm = (p == 3);
         queue_random(125, eff + $urandom_range(1, 6));
         settle();
      end
      calm = 1'b0;

      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
